// ----- rtl/cdps_pkg.sv -----
`default_nettype none

package cdps_pkg;

	localparam int LINES_DEF = 12;
	localparam int LINES_MAX = 16;
	localparam int LINE_W    = 20;
	localparam int DLY_W     = 24;
	localparam int WANT_W    = 25;
	localparam int ERR_W     = 26;
	localparam int PAT_W     = 12;
	localparam int WIN_W     = 24;
	localparam int IDX_IN_W  = 4;

	localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(10000);

	localparam logic [LINE_W-1:0] LINE_RESET [LINES_MAX] = '{
		20'd50,    20'd145,   20'd250,   20'd816,
		20'd1015,  20'd1764,  20'd3527,  20'd6727,
		20'd12982, 20'd25455, 20'd50474, 20'd100880,
		20'd0,     20'd0,     20'd0,     20'd0
	};

	typedef struct packed {
		logic valid;
		logic last;
	} walk_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/cdps_walker.sv -----
`default_nettype none

module cdps_walker import cdps_pkg::*; #(
	parameter int NUM_LINES = LINES_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    wr_en,
	input  wire logic [IDX_IN_W-1:0]     wr_idx,
	input  wire logic [LINE_W-1:0]       wr_data,
	input  wire logic                    start,
	output walk_ctl_t                    ctl,
	output logic      [NUM_LINES-1:0]    pat,
	output logic      [DLY_W-1:0]        dly
);

	localparam int IDX_W = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;

	logic [LINE_W-1:0]    line_q [NUM_LINES];
	logic [NUM_LINES-1:0] cnt_q;
	logic [NUM_LINES-1:0] pat_q;
	logic [DLY_W-1:0]     dly_q;
	logic                 run_q;
	logic [IDX_W-1:0]     flip;
	logic [DLY_W-1:0]     step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_LINES; i++) begin
				line_q[i] <= LINE_RESET[i];
			end
		end else if (wr_en && (32'(wr_idx) < NUM_LINES)) begin
			line_q[wr_idx[IDX_W-1:0]] <= wr_data;
		end
	end

	// next Gray step flips the bit above the trailing ones of the count
	always_comb begin
		flip = '0;
		for (int i = NUM_LINES - 1; i >= 0; i--) begin
			if (!cnt_q[i]) begin
				flip = IDX_W'(i);
			end
		end
		step = DLY_W'(line_q[flip]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
			pat_q <= '0;
			dly_q <= '0;
		end else if (start) begin
			run_q <= 1'b1;
			cnt_q <= '0;
			pat_q <= '0;
			dly_q <= '0;
		end else if (run_q) begin
			if (&cnt_q) begin
				run_q <= 1'b0;
			end else begin
				cnt_q       <= cnt_q + 1'b1;
				pat_q[flip] <= !pat_q[flip];
				dly_q       <= pat_q[flip] ? dly_q - step : dly_q + step;
			end
		end
	end

	assign ctl.valid = run_q;
	assign ctl.last  = &cnt_q;
	assign pat       = pat_q;
	assign dly       = dly_q;

endmodule

`default_nettype wire

// ----- rtl/closest_delay_pattern_search_unit.sv -----
// Write request: no result.
// Query request: one Gray-code walk with a single add/subtract accumulator runs twice, first
// for the best match, then for its sorted neighbors. One request at a time: no new request
// is taken until the previous query has finished; a finished query waits while the output
// register still holds an unread result.
// Reset (arst_n, asynchronous): line delays and search window take their default values.
`default_nettype none

module closest_delay_pattern_search_unit import cdps_pkg::*; #(
	parameter int NUM_LINES = LINES_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [55:0]  s_tdata,   // line_index, line_delay, desired_delay, pad
	input  wire logic         s_tuser,   // func
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic      [111:0] m_tdata,   // best_delay, pattern_bits, delay_error,
	                                     // lower_delay, upper_delay, pad
	input  wire logic         cfg_wen,
	input  wire logic [23:0]  cfg_wdata
);

	localparam int KEY_W = DLY_W + NUM_LINES;

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN1, ST_SCAN2, ST_FINISH} state_t;

	state_t               state_q;
	logic [WIN_W-1:0]     win_q;
	logic [WANT_W-1:0]    want_q;

	logic                 s_accept;
	logic                 wr_en;
	logic                 walk_start;
	walk_ctl_t            walk_ctl;
	logic [NUM_LINES-1:0] walk_pat;
	logic [DLY_W-1:0]     walk_dly;

	walk_ctl_t            ctl_s2;
	logic [NUM_LINES-1:0] pat_s2;
	logic [DLY_W-1:0]     dly_s2;
	logic [ERR_W-1:0]     dist_s2;

	logic signed [ERR_W-1:0] diff;
	logic [ERR_W-1:0]        dist_abs;

	logic                 found_q;
	logic [ERR_W-1:0]     best_dist_q;
	logic [DLY_W-1:0]     best_dly_q;
	logic [NUM_LINES-1:0] best_pat_q;
	logic                 have_lo_q;
	logic                 have_hi_q;
	logic [KEY_W-1:0]     lo_key_q;
	logic [KEY_W-1:0]     hi_key_q;

	logic [KEY_W-1:0]     key_s2;
	logic [KEY_W-1:0]     best_key;
	logic                 better;
	logic                 take_lo;
	logic                 take_hi;
	logic                 scan_end;
	logic                 fin_load;

	logic [DLY_W-1:0]     out_best_q;
	logic [PAT_W-1:0]     out_pat_q;
	logic [ERR_W-1:0]     out_err_q;
	logic [DLY_W-1:0]     out_lo_q;
	logic [DLY_W-1:0]     out_hi_q;
	logic [LINES_MAX-1:0] pat_ext;

	assign s_tready   = (state_q == ST_IDLE);
	assign s_accept   = s_tvalid && s_tready;
	assign wr_en      = s_accept && !s_tuser;
	assign scan_end   = ctl_s2.valid && ctl_s2.last;
	assign walk_start = (s_accept && s_tuser) || ((state_q == ST_SCAN1) && scan_end);
	assign fin_load   = (state_q == ST_FINISH) && (!m_tvalid || m_tready);

	cdps_walker #(
		.NUM_LINES(NUM_LINES)
	) u_walker (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (wr_en),
		.wr_idx (s_tdata[3:0]),
		.wr_data(s_tdata[23:4]),
		.start  (walk_start),
		.ctl    (walk_ctl),
		.pat    (walk_pat),
		.dly    (walk_dly)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= WIN_RESET;
		end else if (cfg_wen) begin
			win_q <= cfg_wdata;
		end
	end

	always_comb begin
		diff     = $signed({2'b00, walk_dly}) - $signed({want_q[WANT_W-1], want_q});
		dist_abs = diff[ERR_W-1] ? ERR_W'(-diff) : ERR_W'(diff);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else begin
			ctl_s2 <= walk_ctl;
		end
	end

	always_ff @(posedge clk) begin
		pat_s2  <= walk_pat;
		dly_s2  <= walk_dly;
		dist_s2 <= dist_abs;
	end

	always_comb begin
		key_s2   = {dly_s2, pat_s2};
		best_key = {best_dly_q, best_pat_q};
		better   = (dist_s2 < ERR_W'(win_q)) &&
		           (!found_q || (dist_s2 < best_dist_q) ||
		            ((dist_s2 == best_dist_q) &&
		             ((dly_s2 < best_dly_q) ||
		              ((dly_s2 == best_dly_q) && (pat_s2 < best_pat_q)))));
		take_lo  = (key_s2 < best_key) && (!have_lo_q || (key_s2 > lo_key_q));
		take_hi  = (key_s2 > best_key) && (!have_hi_q || (key_s2 < hi_key_q));
		pat_ext  = '0;
		pat_ext[NUM_LINES-1:0] = best_pat_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			m_tvalid    <= 1'b0;
			found_q     <= 1'b0;
			have_lo_q   <= 1'b0;
			have_hi_q   <= 1'b0;
			want_q      <= '0;
			best_dist_q <= '0;
			best_dly_q  <= '0;
			best_pat_q  <= '0;
			lo_key_q    <= '0;
			hi_key_q    <= '0;
			out_best_q  <= '0;
			out_pat_q   <= '0;
			out_err_q   <= '0;
			out_lo_q    <= '0;
			out_hi_q    <= '0;
		end else begin
			if (fin_load) begin
				m_tvalid <= 1'b1;
			end else if (m_tvalid && m_tready) begin
				m_tvalid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_accept && s_tuser) begin
						want_q  <= s_tdata[48:24];
						found_q <= 1'b0;
						state_q <= ST_SCAN1;
					end
				end
				ST_SCAN1: begin
					if (ctl_s2.valid && better) begin
						found_q     <= 1'b1;
						best_dist_q <= dist_s2;
						best_dly_q  <= dly_s2;
						best_pat_q  <= pat_s2;
					end
					if (scan_end) begin
						// no match in the window: fall back to the empty pattern
						if (!found_q && !better) begin
							best_dly_q <= '0;
							best_pat_q <= '0;
						end
						have_lo_q <= 1'b0;
						have_hi_q <= 1'b0;
						state_q   <= ST_SCAN2;
					end
				end
				ST_SCAN2: begin
					if (ctl_s2.valid && take_lo) begin
						have_lo_q <= 1'b1;
						lo_key_q  <= key_s2;
					end
					if (ctl_s2.valid && take_hi) begin
						have_hi_q <= 1'b1;
						hi_key_q  <= key_s2;
					end
					if (scan_end) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (fin_load) begin
						out_best_q <= best_dly_q;
						out_pat_q  <= pat_ext[PAT_W-1:0];
						out_err_q  <= ERR_W'($signed({2'b00, best_dly_q}) -
						                     $signed({want_q[WANT_W-1], want_q}));
						out_lo_q   <= have_lo_q ? lo_key_q[KEY_W-1 -: DLY_W] : best_dly_q;
						out_hi_q   <= have_hi_q ? hi_key_q[KEY_W-1 -: DLY_W] : best_dly_q;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tdata = {2'b00, out_hi_q, out_lo_q, out_err_q, out_pat_q, out_best_q};

endmodule

`default_nettype wire
